// ===== sv/sv39pt_pkg.sv =====
// Shared types and constants for the Sv39 page table engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sv39pt_pkg;
  localparam int unsigned EntryW   = 54;
  localparam int unsigned SlotW    = 9;
  localparam int unsigned PpnW     = 44;
  localparam int unsigned MaxRun   = 64;
  localparam logic [43:0] PoolBaseRst = 44'h000_0008_0000;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_MAP    = 2'd1,
    ACT_UNMAP  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_POOL    = 3'd2,
    ST_REMAP   = 3'd3,
    ST_UNMAPPED = 3'd4
  } status_e;

  typedef logic [EntryW-1:0] entry_t;
endpackage
`default_nettype wire

// ===== sv/sv39pt_tbl.sv =====
// Table page store: single port synchronous memory with a registered read.
// Depends on sv39pt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sv39pt_tbl #(
  parameter int unsigned AW = 13
) (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       addr_i,
  input  wire sv39pt_pkg::entry_t  wdata_i,
  output sv39pt_pkg::entry_t       rdata_o
);
  sv39pt_pkg::entry_t mem_q [2**AW];
  sv39pt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== sv/sv39_page_table_map_unmap.sv =====
// Sv39 page table map/unmap/lookup engine over an internal pool of table pages.
// Each page runs from the transfer or the previous page through check, three
// read/evaluate pairs and emit; each new table page adds a zeroing sweep of the whole page.
// One request at a time; the next transfer can be taken in the cycle after the last
// result is registered; a map or unmap run gives one result per page until a failing page ends it.
// After reset the root page is zeroed before the first transfer is taken.
// Depends on sv39pt_pkg and sv39pt_tbl.
`timescale 1ns / 1ps
`default_nettype none
module sv39_page_table_map_unmap #(
  parameter int unsigned POOL_PAGES = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [43:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // virt_addr[38:0], phys_addr[94:39], page_count[101:95], perm_bits[109:102],
  // free_frame[110], zero[111]
  input  wire logic [111:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], page_va[41:3], leaf_entry[95:42], freed_pa[151:96],
  // free_valid[152], zero[159:153]
  output logic [159:0]      m_axis_tdata,
  output logic              m_axis_tlast
);
  localparam int unsigned PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned AW = PW + sv39pt_pkg::SlotW;
  localparam int unsigned NW = $clog2(POOL_PAGES + 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_CHECK, S_RD, S_EVAL, S_EMIT
  } state_e;

  state_e              state_q;
  logic                boot_q;
  logic [1:0]          act_q;
  logic [26:0]         base_q;
  logic [43:0]         pa_q;
  logic [6:0]          cnt_q, k_q;
  logic [7:0]          perm_q;
  logic                free_q;
  logic [26:0]         vpn_q;
  logic [1:0]          lvl_q;
  logic [PW-1:0]       pg_q;
  logic [AW-1:0]       addr_q;
  logic [NW-1:0]       nfree_q;
  logic [43:0]         pbase_q;
  logic [8:0]          clr_q;
  logic [2:0]          res_st_q;
  sv39pt_pkg::entry_t  res_leaf_q;
  logic [55:0]         res_freed_q;
  logic                res_fv_q, res_last_q;
  logic                mv_q;
  logic [159:0]        md_q;
  logic                ml_q;

  logic                mem_en, mem_we;
  logic [AW-1:0]       mem_addr;
  sv39pt_pkg::entry_t  mem_wdata, rdata;
  logic [8:0]          vpn_sel;
  logic [43:0]         idx;
  logic [6:0]          cnt_in;
  logic                alloc, is_last;
  sv39pt_pkg::entry_t  ptr, leaf;

  always_comb begin
    case (lvl_q)
      2'd2:    vpn_sel = vpn_q[26:18];
      2'd1:    vpn_sel = vpn_q[17:9];
      default: vpn_sel = vpn_q[8:0];
    endcase
  end

  assign alloc   = (act_q == sv39pt_pkg::ACT_MAP);
  assign idx     = rdata[53:10] - pbase_q;
  assign ptr     = {pbase_q + 44'(nfree_q), 10'd1};
  assign leaf    = {pa_q + 44'(k_q), 2'b00, perm_q | 8'd1};
  assign is_last = (k_q == cnt_q - 7'd1);

  always_comb begin
    cnt_in = s_axis_tdata[101:95];
    if (s_axis_tuser == sv39pt_pkg::ACT_LOOKUP || cnt_in == 7'd0) begin
      cnt_in = 7'd1;
    end else if (cnt_in > 7'(sv39pt_pkg::MaxRun)) begin
      cnt_in = 7'(sv39pt_pkg::MaxRun);
    end
  end

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = '0;
    unique case (state_q)
      S_CLR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = {pg_q, clr_q};
      end
      S_RD: begin
        mem_en   = 1'b1;
        mem_addr = {pg_q, vpn_sel};
      end
      S_EVAL: begin
        if (lvl_q != 2'd0) begin
          if (!rdata[0] && alloc && nfree_q < NW'(POOL_PAGES)) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = ptr;
          end
        end else if (act_q == sv39pt_pkg::ACT_MAP && !rdata[0]) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = leaf;
        end else if (act_q == sv39pt_pkg::ACT_UNMAP && rdata[0]) begin
          mem_en = 1'b1;
          mem_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  sv39pt_tbl #(.AW(AW)) u_tbl (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      boot_q  <= 1'b1;
      pg_q    <= '0;
      clr_q   <= '0;
      nfree_q <= NW'(1);
      pbase_q <= sv39pt_pkg::PoolBaseRst;
      mv_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pbase_q <= cfg_wdata_i;
      end
      if (mv_q && m_axis_tready && state_q != S_EMIT) begin
        mv_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 9'd1;
          if (clr_q == 9'h1ff) begin
            boot_q  <= 1'b0;
            state_q <= boot_q ? S_IDLE : S_RD;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act_q  <= s_axis_tuser;
            base_q <= s_axis_tdata[38:12];
            pa_q   <= s_axis_tdata[94:51];
            cnt_q  <= cnt_in;
            perm_q <= s_axis_tdata[109:102];
            free_q <= s_axis_tdata[110];
            k_q    <= '0;
            if (s_axis_tuser != sv39pt_pkg::ACT_NONE) begin
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          vpn_q      <= base_q + 27'(k_q);
          pg_q       <= '0;
          lvl_q      <= 2'd2;
          res_leaf_q <= '0;
          res_freed_q <= '0;
          res_fv_q   <= 1'b0;
          res_last_q <= 1'b1;
          if (({1'b0, base_q} + 28'(k_q)) > 28'h7ffffff) begin
            res_st_q <= sv39pt_pkg::ST_RANGE;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          addr_q  <= mem_addr;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (lvl_q != 2'd0) begin
            if (rdata[0]) begin
              if (idx >= 44'(nfree_q)) begin
                res_st_q <= alloc ? sv39pt_pkg::ST_POOL : sv39pt_pkg::ST_UNMAPPED;
                state_q  <= S_EMIT;
              end else begin
                pg_q    <= idx[PW-1:0];
                lvl_q   <= lvl_q - 2'd1;
                state_q <= S_RD;
              end
            end else if (!alloc) begin
              res_st_q <= sv39pt_pkg::ST_UNMAPPED;
              state_q  <= S_EMIT;
            end else if (nfree_q >= NW'(POOL_PAGES)) begin
              res_st_q <= sv39pt_pkg::ST_POOL;
              state_q  <= S_EMIT;
            end else begin
              pg_q    <= nfree_q[PW-1:0];
              nfree_q <= nfree_q + NW'(1);
              lvl_q   <= lvl_q - 2'd1;
              clr_q   <= '0;
              state_q <= S_CLR;
            end
          end else begin
            state_q <= S_EMIT;
            unique case (act_q)
              sv39pt_pkg::ACT_MAP: begin
                if (rdata[0]) begin
                  res_st_q <= sv39pt_pkg::ST_REMAP;
                end else begin
                  res_st_q   <= sv39pt_pkg::ST_OK;
                  res_leaf_q <= leaf;
                  res_last_q <= is_last;
                end
              end
              sv39pt_pkg::ACT_UNMAP: begin
                if (!rdata[0]) begin
                  res_st_q <= sv39pt_pkg::ST_UNMAPPED;
                end else begin
                  res_st_q   <= sv39pt_pkg::ST_OK;
                  res_last_q <= is_last;
                  if (free_q) begin
                    res_freed_q <= {rdata[53:10], 12'd0};
                    res_fv_q    <= 1'b1;
                  end
                end
              end
              default: begin
                res_st_q   <= sv39pt_pkg::ST_OK;
                res_leaf_q <= rdata;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (!mv_q || m_axis_tready) begin
            mv_q <= 1'b1;
            md_q <= {7'd0, res_fv_q, res_freed_q, res_leaf_q, vpn_q, 12'd0,
                     res_st_q};
            ml_q <= res_last_q;
            if (res_last_q) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 7'd1;
              state_q <= S_CHECK;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tlast  = ml_q;
endmodule
`default_nettype wire
